// ----- hw/rtl/bld_pkg.sv -----
// Shared types and constants for the bitplane line drawing engine.
// Used by bld_ctrl, bld_datapath and the top level; depends on nothing.
package bld_pkg;

	// Default sizes handed to the top-level parameters
	localparam int unsigned DEF_MAX_WIDTH       = 512;
	localparam int unsigned DEF_MAX_HEIGHT      = 512;
	localparam int unsigned DEF_MAX_PLANES      = 3;
	localparam int unsigned DEF_PALETTE_ENTRIES = 8;

	// Fixed field widths
	localparam int unsigned COORD_W     = 9;
	localparam int unsigned COLOR_W     = 3;
	localparam int unsigned DIM_W       = 10;
	localparam int unsigned PCOUNT_W    = 2;
	localparam int unsigned PALETTE_W   = 24;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned COUNT_W     = 12;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned RPLANE_W    = 2;
	localparam int unsigned RADDR_W     = 15;
	localparam int unsigned ERR_W       = 12;

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_LINE  = 3'd1,
		OP_BOX   = 3'd2,
		OP_CLEAR = 3'd3,
		OP_READ  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_PLANES  = 2'd2,
		REG_PALETTE = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEG,
		S_CHECK,
		S_PRD,
		S_PWR,
		S_CLR_SET,
		S_CLR,
		S_RD_ISSUE,
		S_RD_CAP,
		S_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       seg_load;
		logic [1:0] seg;
		logic       pix_rd;
		logic       pix_wr;
		logic       clr_set;
		logic       clr_wr;
		logic       rd_issue;
		logic       rd_cap;
		logic       res_load;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic at_end;
		logic clr_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/bld_ctrl.sv -----
// Command sequencer for the bitplane line drawing engine.
// Depends on bld_pkg; drives bld_datapath through dp_cmd_t.
module bld_ctrl
	import bld_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         opcode,
	input  dp_status_t         status,
	output dp_cmd_t            cmd
);

	state_t     state_q, state_d;
	opcode_t    op_q;
	logic [1:0] seg_q;
	logic       seg_adv;

	// State, opcode and segment registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_PIXEL;
			seg_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q  <= opcode_t'(opcode);
				seg_q <= 2'd0;
			end else if (seg_adv) begin
				seg_q <= seg_q + 2'd1;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.seg  = seg_q;
		in_stall = 1'b1;
		seg_adv  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (opcode_t'(opcode))
						OP_PIXEL: state_d = S_PRD;
						OP_LINE:  state_d = S_SEG;
						OP_BOX:   state_d = S_SEG;
						OP_CLEAR: state_d = S_CLR_SET;
						OP_READ:  state_d = S_RD_ISSUE;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_SEG: begin
				cmd.seg_load = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				if (status.at_end) begin
					if (op_q == OP_BOX && seg_q != 2'd3) begin
						seg_adv = 1'b1;
						state_d = S_SEG;
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				cmd.pix_rd = 1'b1;
				state_d    = S_PWR;
			end
			S_PWR: begin
				cmd.pix_wr = 1'b1;
				state_d    = (op_q == OP_PIXEL) ? S_DONE : S_CHECK;
			end
			S_CLR_SET: begin
				cmd.clr_set = 1'b1;
				state_d     = S_CLR;
			end
			S_CLR: begin
				if (status.clr_done) begin
					state_d = S_DONE;
				end else begin
					cmd.clr_wr = 1'b1;
				end
			end
			S_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RD_CAP;
			end
			S_RD_CAP: begin
				cmd.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// A taken word always starts a busy period
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken but engine not busy next cycle");

	// A result is only loaded into a free output register
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> status.out_free)
		else $error("result loaded into occupied output register");

	// Every pixel write follows its read
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> $past(cmd.pix_rd))
		else $error("pixel write without preceding read");

endmodule

// ----- hw/rtl/bld_datapath.sv -----
// Line stepper, address generation, plane memories and result register.
// Depends on bld_pkg; controlled by bld_ctrl through dp_cmd_t.
module bld_datapath
	import bld_pkg::*;
#(
	parameter int unsigned MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int unsigned MAX_PLANES      = DEF_MAX_PLANES,
	parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [DIM_W-1:0]     frame_width,
	input  logic [DIM_W-1:0]     frame_height,
	input  logic [PCOUNT_W-1:0]  plane_count,
	input  logic [PALETTE_W-1:0] palette_word,
	input  logic [2:0]           opcode,
	input  logic [COORD_W-1:0]   start_x,
	input  logic [COORD_W-1:0]   start_y,
	input  logic [COORD_W-1:0]   end_x,
	input  logic [COORD_W-1:0]   end_y,
	input  logic [COLOR_W-1:0]   pixel_color,
	input  logic [RPLANE_W-1:0]  read_plane,
	input  logic [RADDR_W-1:0]   read_address,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    read_data,
	output logic [COUNT_W-1:0]   pixels_drawn
);

	localparam int unsigned PLANE_BYTES = (MAX_WIDTH / 8) * MAX_HEIGHT;
	localparam int unsigned AW  = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned NPW = $clog2(MAX_PLANES + 1);
	localparam int unsigned PLW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int unsigned PW  = COORD_W + WW;
	localparam int unsigned LW  = WW + HW;

	// Command fields
	logic [COORD_W-1:0]  x0_q, y0_q, x1_q, y1_q;
	logic [COLOR_W-1:0]  color_q;
	logic                is_box_q;
	logic [RPLANE_W-1:0] rplane_q;
	logic [RADDR_W-1:0]  raddr_q;

	// Line stepper
	logic [COORD_W-1:0]    cx_q, cy_q, ex_q, ey_q, dx_q, dy_q;
	logic                  sxn_q, syn_q;
	logic signed [ERR_W-1:0] err_q;

	// Pixel access
	logic [AW-1:0]      addr_q;
	logic               inframe_q;
	logic [BYTE_W-1:0]  mask_q;
	logic [AW:0]        len_q, clr_addr_q;
	logic [COUNT_W-1:0] count_q;
	logic [BYTE_W-1:0]  data_q;
	logic               rd_ok_q;
	logic [BYTE_W-1:0]  rdata_q [MAX_PLANES];

	// Result register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  read_data_q;
	logic [COUNT_W-1:0] pixels_drawn_q;

	// Effective frame and plane count
	logic [WW-1:0]  ew_sat, ew;
	logic [HW-1:0]  eh;
	logic [NPW-1:0] np;

	assign ew_sat = (32'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
	assign ew     = ew_sat & ~WW'(7);
	assign eh     = (32'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
	assign np     = (32'(plane_count) > MAX_PLANES) ? NPW'(MAX_PLANES) : NPW'(plane_count);

	// Map color through the palette when three planes are in use
	logic [COLOR_W-1:0] pidx, mapped;
	always_comb begin
		pidx = pixel_color;
		for (int i = 0; i < 3; i++) begin
			if (32'(pidx) >= PALETTE_ENTRIES) begin
				pidx = pidx - COLOR_W'(PALETTE_ENTRIES);
			end
		end
		mapped = (plane_count == 2'd3) ? palette_word[32'(pidx) * 3 +: 3] : pixel_color;
	end

	// Segment endpoints
	logic [COORD_W-1:0] sgx0, sgy0, sgx1, sgy1;
	always_comb begin
		unique case (cmd.seg)
			2'd0: begin
				sgx0 = x0_q; sgy0 = y0_q; sgx1 = x1_q; sgy1 = is_box_q ? y0_q : y1_q;
			end
			2'd1: begin
				sgx0 = x1_q; sgy0 = y0_q; sgx1 = x1_q; sgy1 = y1_q;
			end
			2'd2: begin
				sgx0 = x1_q; sgy0 = y1_q; sgx1 = x0_q; sgy1 = y1_q;
			end
			default: begin
				sgx0 = x0_q; sgy0 = y1_q; sgx1 = x0_q; sgy1 = y0_q;
			end
		endcase
	end

	logic [COORD_W-1:0] sdx, sdy;
	assign sdx = (sgx1 > sgx0) ? sgx1 - sgx0 : sgx0 - sgx1;
	assign sdy = (sgy1 > sgy0) ? sgy1 - sgy0 : sgy0 - sgy1;

	// Bresenham error step
	logic signed [ERR_W:0]   e2, dxs, dys, err_n;
	logic                    step_x, step_y;
	always_comb begin
		dxs    = $signed({4'b0, dx_q});
		dys    = $signed({4'b0, dy_q});
		e2     = $signed({err_q, 1'b0});
		step_x = e2 > -dys;
		step_y = e2 < dxs;
		err_n  = $signed({err_q[ERR_W-1], err_q});
		if (step_x) begin
			err_n = err_n - dys;
		end
		if (step_y) begin
			err_n = err_n + dxs;
		end
	end

	// Byte address and frame check of the current point
	logic [PW-1:0]     prod;
	logic [AW-1:0]     pix_addr;
	logic              pix_in;
	logic [LW-1:0]     len_full;
	assign prod     = PW'(cy_q) * PW'(ew >> 3);
	assign pix_addr = AW'(prod + PW'(cx_q >> 3));
	assign pix_in   = (32'(cx_q) < 32'(ew)) && (32'(cy_q) < 32'(eh));
	assign len_full = LW'(ew >> 3) * LW'(eh);

	// Command, stepper and counter registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x0_q     <= start_x;
			y0_q     <= start_y;
			x1_q     <= end_x;
			y1_q     <= end_y;
			color_q  <= mapped;
			is_box_q <= (opcode == OP_BOX);
			rplane_q <= read_plane;
			raddr_q  <= read_address;
			cx_q     <= start_x;
			cy_q     <= start_y;
			count_q  <= '0;
			data_q   <= '0;
		end
		if (cmd.seg_load) begin
			cx_q  <= sgx0;
			cy_q  <= sgy0;
			ex_q  <= sgx1;
			ey_q  <= sgy1;
			dx_q  <= sdx;
			dy_q  <= sdy;
			sxn_q <= !(sgx0 < sgx1);
			syn_q <= !(sgy0 < sgy1);
			err_q <= ERR_W'($signed({3'b0, sdx}) - $signed({3'b0, sdy}));
		end
		if (cmd.pix_rd) begin
			addr_q    <= pix_addr;
			inframe_q <= pix_in;
			mask_q    <= BYTE_W'(1) << cx_q[2:0];
		end
		if (cmd.pix_wr) begin
			count_q <= count_q + COUNT_W'(inframe_q);
			err_q   <= ERR_W'(err_n);
			if (step_x) begin
				cx_q <= sxn_q ? cx_q - 1'b1 : cx_q + 1'b1;
			end
			if (step_y) begin
				cy_q <= syn_q ? cy_q - 1'b1 : cy_q + 1'b1;
			end
		end
		if (cmd.clr_set) begin
			len_q      <= (AW + 1)'(len_full);
			clr_addr_q <= '0;
		end
		if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
		if (cmd.rd_issue) begin
			rd_ok_q <= (32'(rplane_q) < MAX_PLANES) && (32'(raddr_q) < PLANE_BYTES);
		end
		if (cmd.rd_cap) begin
			data_q <= rd_ok_q ? rdata_q[PLW'(rplane_q)] : '0;
		end
	end

	// Plane memories, one read-modify-write port each
	logic [AW-1:0] mem_raddr, mem_waddr;
	assign mem_raddr = cmd.rd_issue ? AW'(raddr_q) : pix_addr;
	assign mem_waddr = cmd.clr_wr ? clr_addr_q[AW-1:0] : addr_q;

	for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
		logic [BYTE_W-1:0] plane_mem_q [PLANE_BYTES];
		logic              cbit, en, we;
		logic [BYTE_W-1:0] wdata;

		if (p < COLOR_W) begin : g_cbit
			assign cbit = color_q[p];
		end else begin : g_zero
			assign cbit = 1'b0;
		end

		assign en    = 32'(np) > p;
		assign we    = en && ((cmd.pix_wr && inframe_q) || cmd.clr_wr);
		assign wdata = cmd.clr_wr ? {BYTE_W{cbit}} :
			(cbit ? (rdata_q[p] | mask_q) : (rdata_q[p] & ~mask_q));

		always_ff @(posedge clk) begin
			if (we) begin
				plane_mem_q[mem_waddr] <= wdata;
			end
			rdata_q[p] <= plane_mem_q[mem_raddr];
		end
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			read_data_q    <= data_q;
			pixels_drawn_q <= count_q;
		end
	end

	assign status.at_end   = (cx_q == ex_q) && (cy_q == ey_q);
	assign status.clr_done = (clr_addr_q == len_q);
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign pixels_drawn = pixels_drawn_q;

endmodule

// ----- hw/rtl/bitplane_line_drawing_engine.sv -----
// Top level of the bitplane line drawing engine: configuration registers,
// command sequencer and datapath. Depends on bld_pkg, bld_ctrl, bld_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one command word: set pixel,
//   line, box, clear or read byte. Output channel (out_valid/out_stall)
//   returns one result word per command: read_data and pixels_drawn.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Timing:
//   One command is worked at a time. Each pixel of a line or box passes
//   through an end check, a memory read and a memory write, and a box is
//   drawn as four segments. A clear steps through the bytes of a plane and
//   fills all planes in use in parallel. The single read-modify-write port
//   of the plane memories sets the pixel rate.
// Reset:
//   arst_n clears the sequencer and the output register and restores the
//   configuration defaults. Plane memory is not cleared; issue a clear first.
// Backpressure:
//   A finished result waits in the output register while out_stall is high;
//   the next command may already be accepted and worked, and its result is
//   held back until the register frees.
module bitplane_line_drawing_engine
	import bld_pkg::*;
#(
	parameter int unsigned MAX_WIDTH       = DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT      = DEF_MAX_HEIGHT,
	parameter int unsigned MAX_PLANES      = DEF_MAX_PLANES,
	parameter int unsigned PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             opcode,
	input  logic [COORD_W-1:0]     start_x,
	input  logic [COORD_W-1:0]     start_y,
	input  logic [COORD_W-1:0]     end_x,
	input  logic [COORD_W-1:0]     end_y,
	input  logic [COLOR_W-1:0]     pixel_color,
	input  logic [RPLANE_W-1:0]    read_plane,
	input  logic [RADDR_W-1:0]     read_address,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_W-1:0]      read_data,
	output logic [COUNT_W-1:0]     pixels_drawn
);

	logic [DIM_W-1:0]     frame_width_q, frame_height_q;
	logic [PCOUNT_W-1:0]  plane_count_q;
	logic [PALETTE_W-1:0] palette_word_q;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(512);
			frame_height_q <= DIM_W'(512);
			plane_count_q  <= PCOUNT_W'(1);
			palette_word_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:   frame_width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:  frame_height_q <= cfg_data[DIM_W-1:0];
				REG_PLANES:  plane_count_q  <= cfg_data[PCOUNT_W-1:0];
				REG_PALETTE: palette_word_q <= cfg_data[PALETTE_W-1:0];
				default:     ;
			endcase
		end
	end

	dp_cmd_t    cmd;
	dp_status_t status;

	bld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.status   (status),
		.cmd      (cmd)
	);

	bld_datapath #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_HEIGHT      (MAX_HEIGHT),
		.MAX_PLANES      (MAX_PLANES),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.plane_count  (plane_count_q),
		.palette_word (palette_word_q),
		.opcode       (opcode),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.pixel_color  (pixel_color),
		.read_plane   (read_plane),
		.read_address (read_address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.pixels_drawn (pixels_drawn)
	);

endmodule

// ----- bench/bld_checker.sv -----
// Result checker for the bitplane line drawing engine: shadows the
// configuration and the plane memory, predicts each result word and compares.
// Depends on bld_pkg for field widths and command codes.
module bld_checker
	import bld_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [2:0]             opcode,
	input  logic [COORD_W-1:0]     start_x,
	input  logic [COORD_W-1:0]     start_y,
	input  logic [COORD_W-1:0]     end_x,
	input  logic [COORD_W-1:0]     end_y,
	input  logic [COLOR_W-1:0]     pixel_color,
	input  logic [RPLANE_W-1:0]    read_plane,
	input  logic [RADDR_W-1:0]     read_address,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic [BYTE_W-1:0]      read_data,
	input  logic [COUNT_W-1:0]     pixels_drawn,
	output int                     fail_count,
	output int                     pending,
	output int                     words_checked
);
	localparam int PLANE_SIZE = (DEF_MAX_WIDTH / 8) * DEF_MAX_HEIGHT;

	typedef struct {
		logic [BYTE_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} draw_result_t;

	logic [7:0]           fb_shadow [0:DEF_MAX_PLANES*PLANE_SIZE-1];
	logic [DIM_W-1:0]     width_reg;
	logic [DIM_W-1:0]     height_reg;
	logic [PCOUNT_W-1:0]  planes_reg;
	logic [PALETTE_W-1:0] palette_reg;
	draw_result_t         result_q [$];

	function automatic int used_width();
		int w;
		w = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
		return w & ~7;
	endfunction

	function automatic int used_height();
		return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
	endfunction

	function automatic int used_planes();
		return (planes_reg > DEF_MAX_PLANES) ? DEF_MAX_PLANES : int'(planes_reg);
	endfunction

	// Write one pixel into every plane in use; return 1 if it lands in frame
	function automatic int plot(int x, int y, logic [2:0] c);
		int w, byte_idx;
		logic [7:0] mask;
		w = used_width();
		if (x < 0 || y < 0 || x >= w || y >= used_height())
			return 0;
		byte_idx = (x >> 3) + y * (w >> 3);
		mask = 8'h01 << (x & 7);
		for (int p = 0; p < used_planes(); p++) begin
			if (c[p])
				fb_shadow[p*PLANE_SIZE+byte_idx] = fb_shadow[p*PLANE_SIZE+byte_idx] | mask;
			else
				fb_shadow[p*PLANE_SIZE+byte_idx] = fb_shadow[p*PLANE_SIZE+byte_idx] & ~mask;
		end
		return 1;
	endfunction

	// Bresenham stepping; the end point itself is not drawn
	function automatic int trace(int x0, int y0, int x1, int y1, logic [2:0] c);
		int dx, dy, sx, sy, err, e2, n;
		dx = (x1 > x0) ? x1 - x0 : x0 - x1;
		dy = (y1 > y0) ? y1 - y0 : y0 - y1;
		sx = (x0 < x1) ? 1 : -1;
		sy = (y0 < y1) ? 1 : -1;
		err = dx - dy;
		n = 0;
		while (x0 != x1 || y0 != y1) begin
			e2 = 2 * err;
			n += plot(x0, y0, c);
			if (e2 > -dy) begin
				err -= dy;
				x0 += sx;
			end
			if (e2 < dx) begin
				err += dx;
				y0 += sy;
			end
		end
		return n;
	endfunction

	// Apply one command to the shadow and return its result word
	function automatic draw_result_t execute(logic [2:0] op, int x0, int y0, int x1,
			int y1, logic [2:0] color, int rplane, int raddr);
		draw_result_t r;
		logic [2:0] c;
		int len, n;
		r.data = '0;
		n = 0;
		c = (planes_reg == 2'd3) ? 3'((palette_reg >> (3 * color)) & 24'h7) : color;
		case (op)
			OP_PIXEL: n = plot(x0, y0, c);
			OP_LINE:  n = trace(x0, y0, x1, y1, c);
			OP_BOX: begin
				n = trace(x0, y0, x1, y0, c);
				n += trace(x1, y0, x1, y1, c);
				n += trace(x1, y1, x0, y1, c);
				n += trace(x0, y1, x0, y0, c);
			end
			OP_CLEAR: begin
				len = (used_width() >> 3) * used_height();
				for (int p = 0; p < used_planes(); p++)
					for (int i = 0; i < len; i++)
						fb_shadow[p*PLANE_SIZE+i] = c[p] ? 8'hff : 8'h00;
			end
			OP_READ: begin
				if (rplane < DEF_MAX_PLANES && raddr < PLANE_SIZE)
					r.data = fb_shadow[rplane*PLANE_SIZE+raddr];
			end
			default: ;
		endcase
		r.count = COUNT_W'(n);
		return r;
	endfunction

	initial begin
		for (int i = 0; i < DEF_MAX_PLANES * PLANE_SIZE; i++)
			fb_shadow[i] = 8'h00;
	end

	assign pending = result_q.size();

	// Track configuration, predict on accepted commands, compare result words
	always @(posedge clk or negedge arst_n) begin
		draw_result_t exp_word;
		int errs;
		errs = 0;
		if (!arst_n) begin
			width_reg     <= DIM_W'(DEF_MAX_WIDTH);
			height_reg    <= DIM_W'(DEF_MAX_HEIGHT);
			planes_reg    <= PCOUNT_W'(1);
			palette_reg   <= '0;
			fail_count    <= 0;
			words_checked <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH:   width_reg   <= cfg_data[DIM_W-1:0];
					REG_HEIGHT:  height_reg  <= cfg_data[DIM_W-1:0];
					REG_PLANES:  planes_reg  <= cfg_data[PCOUNT_W-1:0];
					REG_PALETTE: palette_reg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				result_q.push_back(execute(opcode, start_x, start_y, end_x, end_y,
					pixel_color, read_plane, read_address));
			if (out_valid && !out_stall) begin
				words_checked <= words_checked + 1;
				if (result_q.size() == 0) begin
					$error("unexpected result word: read_data %0d pixels_drawn %0d",
						read_data, pixels_drawn);
					errs++;
				end else begin
					exp_word = result_q.pop_front();
					if (read_data !== exp_word.data) begin
						$error("read_data expected %0d actual %0d", exp_word.data, read_data);
						errs++;
					end
					if (pixels_drawn !== exp_word.count) begin
						$error("pixels_drawn expected %0d actual %0d",
							exp_word.count, pixels_drawn);
						errs++;
					end
				end
				fail_count <= fail_count + errs;
			end
		end
	end
endmodule

// ----- bench/testbench.sv -----
// Top of the bench for the bitplane line drawing engine: clock, reset,
// command and configuration stimulus, result-side stalling and the verdict.
// Depends on bld_pkg, bld_checker and the engine itself.
module testbench;
	import bld_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [2:0]             opcode;
	logic [COORD_W-1:0]     start_x, start_y, end_x, end_y;
	logic [COLOR_W-1:0]     pixel_color;
	logic [RPLANE_W-1:0]    read_plane;
	logic [RADDR_W-1:0]     read_address;
	logic                   out_valid;
	logic                   out_stall;
	logic [BYTE_W-1:0]      read_data;
	logic [COUNT_W-1:0]     pixels_drawn;

	int fail_count, pending, words_checked;
	int cycles;
	int burst_left;
	int commands_sent, lines_sent, boxes_sent, reads_sent, clears_sent, phases_run;
	int frame_w, frame_h;
	bit hold_req;

	bitplane_line_drawing_engine dut (.*);

	bld_checker u_checker (.*);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// Stall results on a shifting duty pattern, with long hold-offs on request
	initial begin
		int duty, hold_left;
		duty = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 500;
			end
			if (cycles % 64 == 0)
				duty = $urandom_range(0, 3) * 30;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < duty);
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_WIDTH)
			frame_w = (val[DIM_W-1:0] > 512) ? 512 : (int'(val[DIM_W-1:0]) & ~7);
		if (idx == REG_HEIGHT)
			frame_h = (val[DIM_W-1:0] > 512) ? 512 : int'(val[DIM_W-1:0]);
	endtask

	// Offer one command word and hold it until taken; gap between bursts
	task automatic send(logic [2:0] op, int x0, int y0, int x1, int y1,
			int color, int rplane, int raddr);
		int gap;
		opcode       <= op;
		start_x      <= COORD_W'(x0);
		start_y      <= COORD_W'(y0);
		end_x        <= COORD_W'(x1);
		end_y        <= COORD_W'(y1);
		pixel_color  <= COLOR_W'(color);
		read_plane   <= RPLANE_W'(rplane);
		read_address <= RADDR_W'(raddr);
		in_valid     <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		commands_sent++;
		if (op == OP_LINE) lines_sent++;
		if (op == OP_BOX) boxes_sent++;
		if (op == OP_READ) reads_sent++;
		if (op == OP_CLEAR) clears_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stop offering and wait for every outstanding result word
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic int clip(int v);
		return (v < 0) ? 0 : (v > 511) ? 511 : v;
	endfunction

	// One random command, mostly short strokes near the frame in use
	task automatic random_command();
		int r, x0, y0, x1, y1, spx, spy;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		spx = clip(frame_w + 8);
		spy = clip(frame_h + 4);
		x0 = $urandom_range(0, spx);
		y0 = $urandom_range(0, spy);
		x1 = clip(x0 + $urandom_range(0, 40) - 20);
		y1 = clip(y0 + $urandom_range(0, 40) - 20);
		if ($urandom_range(0, 24) == 0) begin
			x0 = $urandom_range(0, 511);
			y0 = $urandom_range(0, 511);
			x1 = $urandom_range(0, 511);
			y1 = $urandom_range(0, 511);
		end
		if (r < 22) op = OP_PIXEL;
		else if (r < 52) op = OP_LINE;
		else if (r < 66) op = OP_BOX;
		else if (r < 70) op = ((frame_w / 8) * frame_h <= 4096) ? OP_CLEAR : OP_PIXEL;
		else if (r < 97) op = OP_READ;
		else op = 3'($urandom_range(5, 7));
		send(op, x0, y0, x1, y1, $urandom_range(0, 7), $urandom_range(0, 3),
			$urandom_range(0, 32767));
	endtask

	initial begin
		int widths[$], heights[$];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_PIXEL;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		pixel_color = '0;
		read_plane = '0;
		read_address = '0;
		hold_req = 1'b0;
		burst_left = 4;
		frame_w = 512;
		frame_h = 512;
		commands_sent = 0;
		lines_sent = 0;
		boxes_sent = 0;
		reads_sent = 0;
		clears_sent = 0;
		phases_run = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Full frame, three planes: fill every byte first so reads stay defined
		write_reg(REG_WIDTH, 24'd512);
		write_reg(REG_HEIGHT, 24'd512);
		write_reg(REG_PLANES, 24'd3);
		write_reg(REG_PALETTE, 24'hfac688);
		send(OP_CLEAR, 0, 0, 0, 0, 2, 0, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 0, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 2, 32767);
		send(OP_READ, 0, 0, 0, 0, 0, 3, 32767);
		send(OP_PIXEL, 0, 0, 0, 0, 7, 0, 0);
		send(OP_PIXEL, 511, 511, 0, 0, 0, 0, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 1, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 0, 32767);
		send(OP_LINE, 0, 0, 511, 511, 5, 0, 0);
		send(OP_LINE, 511, 3, 0, 200, 6, 0, 0);
		send(OP_LINE, 40, 40, 40, 40, 7, 0, 0);
		send(OP_LINE, 10, 300, 10, 20, 3, 0, 0);
		send(OP_LINE, 300, 9, 12, 9, 4, 0, 0);
		send(OP_BOX, 0, 0, 511, 511, 1, 0, 0);
		send(OP_BOX, 100, 100, 100, 100, 2, 0, 0);
		send(OP_BOX, 60, 20, 50, 25, 6, 0, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 1, 64 * 511 + 63);
		send(3'd5, 511, 511, 511, 511, 7, 3, 32767);
		send(3'd7, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// Small frame: out-of-frame skipping, plane count zero, and a clear
		write_reg(REG_WIDTH, 24'd21);
		write_reg(REG_HEIGHT, 24'd10);
		write_reg(REG_PLANES, 24'd0);
		send(OP_LINE, 0, 0, 40, 15, 7, 0, 0);
		send(OP_PIXEL, 16, 9, 0, 0, 7, 0, 0);
		send(OP_PIXEL, 15, 10, 0, 0, 7, 0, 0);
		drain();
		write_reg(REG_PLANES, 24'd2);
		send(OP_CLEAR, 0, 0, 0, 0, 1, 0, 0);
		send(OP_READ, 0, 0, 0, 0, 0, 0, 19);
		send(OP_READ, 0, 0, 0, 0, 0, 1, 20);
		drain();

		// Random phases across widths, heights, plane counts and palettes
		widths  = '{8, 512, 64, 1023, 7, 96, 37, 256};
		heights = '{1, 512, 32, 1023, 40, 0, 300, 16};
		for (int ph = 0; ph < widths.size(); ph++) begin
			write_reg(REG_WIDTH, 24'(widths[ph]));
			write_reg(REG_HEIGHT, 24'(heights[ph]));
			write_reg(REG_PLANES, 24'($urandom_range(0, 3)));
			write_reg(REG_PALETTE, 24'($urandom_range(0, 24'hffffff)));
			phases_run++;
			for (int i = 0; i < 170; i++) begin
				if (i == 60)
					hold_req = 1'b1;
				random_command();
			end
			drain();
		end

		$display("sent %0d commands (%0d lines, %0d boxes, %0d reads, %0d clears)",
			commands_sent, lines_sent, boxes_sent, reads_sent, clears_sent);
		$display("checked %0d result words over %0d random configurations",
			words_checked, phases_run);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
